// ===== rtl/ihse_pkg.sv =====
// Package for the image header size extractor.
// Holds the item structs, the parse phase enum, failure codes and header byte tables.
// No dependencies.
`default_nettype none

package ihse_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } ihse_in_t;

  typedef struct packed {
    logic        found;
    logic        image_format;
    logic [31:0] frame_width;
    logic [31:0] frame_height;
    logic [1:0]  fail_cause;
  } ihse_out_t;

  typedef enum logic [3:0] {
    PH_START = 4'd0,
    PH_JHDR  = 4'd1,
    PH_PNG   = 4'd2,
    PH_SKIP  = 4'd3,
    PH_MARK  = 4'd4,
    PH_LENHI = 4'd5,
    PH_LENLO = 4'd6,
    PH_SOF   = 4'd7,
    PH_DONE  = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_SIG   = 2'd1,
    CAUSE_SEG   = 2'd2,
    CAUSE_TRUNC = 2'd3
  } cause_e;

  localparam logic       FMT_JPEG = 1'b0;
  localparam logic       FMT_PNG  = 1'b1;
  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_PNG = 8'h89;
  localparam logic [7:0] MARK_SOF = 8'hC0;

  // JPEG header bytes FF D8 FF E0 len len 'J' 'F' 'I' 'F' 00; length bytes read as zero
  function automatic logic [7:0] jhdr_byte(input logic [4:0] k);
    logic [7:0] b;
    case (k)
      5'd0:    b = 8'hFF;
      5'd1:    b = 8'hD8;
      5'd2:    b = 8'hFF;
      5'd3:    b = 8'hE0;
      5'd6:    b = 8'h4A;
      5'd7:    b = 8'h46;
      5'd8:    b = 8'h49;
      5'd9:    b = 8'h46;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] psig_byte(input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = 8'h89;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'h4E;
      default: b = 8'h47;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/image_header_size_extractor_top.sv =====
// Image header size extractor, top level.
// Parses JPEG/PNG headers byte by byte and returns frame width and height.
// Depends on ihse_pkg.
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+---------------------------
//   in      | input     | ihse_in_t   | in_valid_i / in_stall_o
//   out     | output    | ihse_out_t  | out_valid_o / out_stall_i
//
// One byte per cycle while in_stall_o is low: the edge that accepts an item updates
// the parse state and writes any result into the output register, so out_valid_o
// rises in the cycle after the item is accepted.
// Throughput is one item per clock; stall on the input only while a result
// sits in the output register and the output side stalls.
// Reset puts the parser at the signature check with an empty output register.
`default_nettype none

module image_header_size_extractor_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire ihse_pkg::ihse_in_t in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output ihse_pkg::ihse_out_t out_data_o
);
  import ihse_pkg::*;

  phase_e      phase_q, phase_d;
  logic [4:0]  offset_q, offset_d;
  logic [15:0] skip_q, skip_d;
  logic [7:0]  lenhi_q, lenhi_d;
  logic [31:0] width_q, width_d;
  logic [31:0] height_q, height_d;
  logic        given_q, given_d;

  logic        out_valid_q, out_valid_d;
  ihse_out_t   out_q, out_d;

  logic        accept;
  logic        emit;
  logic        emit_found;
  logic        emit_fmt;
  cause_e      emit_cause;
  logic [7:0]  b;
  logic [15:0] seg_len;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign b           = in_data_i.data_byte;
  assign seg_len     = {lenhi_q, b};

  // parse step for one byte
  always_comb begin
    phase_d    = phase_q;
    offset_d   = offset_q;
    skip_d     = skip_q;
    lenhi_d    = lenhi_q;
    width_d    = width_q;
    height_d   = height_q;
    given_d    = given_q;
    emit       = 1'b0;
    emit_found = 1'b0;
    emit_fmt   = FMT_JPEG;
    emit_cause = CAUSE_NONE;

    if (!given_q) begin
      case (phase_q)
        PH_START: begin
          offset_d = 5'd1;
          if (b == BYTE_FF) begin
            phase_d = PH_JHDR;
          end else if (b == BYTE_PNG) begin
            phase_d = PH_PNG;
          end else begin
            emit       = 1'b1;
            emit_cause = CAUSE_SIG;
          end
        end
        PH_JHDR: begin
          offset_d = offset_q + 5'd1;
          if (offset_q == 5'd4) begin
            lenhi_d = b;
          end else if (offset_q == 5'd5) begin
            skip_d = seg_len;
          end else if (offset_q > 5'd10 || b != jhdr_byte(offset_q)) begin
            emit       = 1'b1;
            emit_cause = CAUSE_SIG;
          end else if (offset_q == 5'd10) begin
            if (skip_q < 16'd7) begin
              emit       = 1'b1;
              emit_cause = CAUSE_SEG;
            end else begin
              skip_d  = skip_q - 16'd7;
              phase_d = PH_SKIP;
            end
          end
        end
        PH_PNG: begin
          offset_d = offset_q + 5'd1;
          if (offset_q < 5'd4) begin
            if (b != psig_byte(offset_q[1:0])) begin
              emit       = 1'b1;
              emit_cause = CAUSE_SIG;
            end
          end else begin
            if (offset_q >= 5'd16 && offset_q <= 5'd19) width_d = {width_q[23:0], b};
            if (offset_q >= 5'd20 && offset_q <= 5'd23) height_d = {height_q[23:0], b};
            if (offset_q >= 5'd23) begin
              emit       = 1'b1;
              emit_found = 1'b1;
              emit_fmt   = FMT_PNG;
            end
          end
        end
        PH_SKIP: begin
          if (skip_q != 16'd0) begin
            skip_d = skip_q - 16'd1;
          end else if (b != BYTE_FF) begin
            emit       = 1'b1;
            emit_cause = CAUSE_SEG;
          end else begin
            phase_d = PH_MARK;
          end
        end
        PH_MARK: begin
          if (b == MARK_SOF) begin
            offset_d = 5'd0;
            width_d  = '0;
            height_d = '0;
            phase_d  = PH_SOF;
          end else begin
            phase_d = PH_LENHI;
          end
        end
        PH_LENHI: begin
          lenhi_d = b;
          phase_d = PH_LENLO;
        end
        PH_LENLO: begin
          if (seg_len < 16'd2) begin
            emit       = 1'b1;
            emit_cause = CAUSE_SEG;
          end else begin
            skip_d  = seg_len - 16'd2;
            phase_d = PH_SKIP;
          end
        end
        PH_SOF: begin
          offset_d = offset_q + 5'd1;
          // JPEG dimensions are 16-bit: keep only the low half
          if (offset_q == 5'd3 || offset_q == 5'd4) height_d = {16'd0, height_q[7:0], b};
          if (offset_q == 5'd5 || offset_q == 5'd6) width_d = {16'd0, width_q[7:0], b};
          if (offset_q >= 5'd6) begin
            emit       = 1'b1;
            emit_found = 1'b1;
            emit_fmt   = FMT_JPEG;
          end
        end
        default: begin
        end
      endcase
    end

    if (emit) begin
      given_d = 1'b1;
      phase_d = PH_DONE;
    end

    // last byte: truncation failure if still undecided, then rearm
    if (in_data_i.final_byte) begin
      if (!emit && !given_q) begin
        emit       = 1'b1;
        emit_found = 1'b0;
        emit_cause = CAUSE_TRUNC;
      end
      phase_d  = PH_START;
      offset_d = '0;
      skip_d   = '0;
      lenhi_d  = '0;
      given_d  = 1'b0;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    if (accept && emit) begin
      out_valid_d        = 1'b1;
      out_d.found        = emit_found;
      out_d.image_format = emit_found ? emit_fmt : FMT_JPEG;
      out_d.frame_width  = emit_found ? width_d : 32'd0;
      out_d.frame_height = emit_found ? height_d : 32'd0;
      out_d.fail_cause   = emit_cause;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      offset_q    <= '0;
      skip_q      <= '0;
      lenhi_q     <= '0;
      width_q     <= '0;
      height_q    <= '0;
      given_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q  <= phase_d;
        offset_q <= offset_d;
        skip_q   <= skip_d;
        lenhi_q  <= lenhi_d;
        given_q  <= given_d;
        if (in_data_i.final_byte) begin
          width_q  <= '0;
          height_q <= '0;
        end else begin
          width_q  <= width_d;
          height_q <= height_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

`default_nettype wire

// ===== tb/ihse_checker.sv =====
// Checker for the image header size extractor: watches both channels, predicts
// the result of every accepted byte and compares it against the output channel.
// Depends on ihse_pkg.
`timescale 1ns / 1ps

module ihse_checker (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_stall_i,
  input  ihse_pkg::ihse_in_t  in_data_i,
  input  wire                 out_valid_i,
  input  wire                 out_stall_i,
  input  ihse_pkg::ihse_out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import ihse_pkg::*;

  localparam logic [87:0] JFIF_LEAD = 88'hFFD8FFE0_0000_4A464946_00;
  localparam logic [31:0] PNG_SIG   = 32'h89504E47;

  phase_e      ph;
  logic [4:0]  hoff;
  logic [15:0] skip_left;
  logic [7:0]  len_hi;
  logic [31:0] wcap;
  logic [31:0] hcap;
  logic        decided;

  ihse_out_t   dims_due[$];
  int          fails;

  function automatic void rearm();
    ph        = PH_START;
    hoff      = '0;
    skip_left = '0;
    len_hi    = '0;
    wcap      = '0;
    hcap      = '0;
    decided   = 1'b0;
  endfunction

  function automatic ihse_out_t close_image(input logic found, input logic fmt,
                                            input cause_e cause);
    ihse_out_t r;
    r.found        = found;
    r.image_format = found ? fmt : FMT_JPEG;
    r.frame_width  = found ? wcap : '0;
    r.frame_height = found ? hcap : '0;
    r.fail_cause   = cause;
    decided = 1'b1;
    ph      = PH_DONE;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output ihse_out_t r);
    int          k;
    bit          hit;
    logic [15:0] seg_len;
    k   = int'(hoff);
    hit = 1'b0;
    r   = '0;
    case (ph)
      PH_START: begin
        hoff = 5'd1;
        if (b == BYTE_FF) begin
          ph = PH_JHDR;
        end else if (b == BYTE_PNG) begin
          ph = PH_PNG;
        end else begin
          r = close_image(1'b0, FMT_JPEG, CAUSE_SIG);
          hit = 1'b1;
        end
      end
      PH_JHDR: begin
        hoff = hoff + 5'd1;
        if (k == 4) begin
          len_hi = b;
        end else if (k == 5) begin
          skip_left = {len_hi, b};
        end else if (k > 10 || b != JFIF_LEAD[87 - 8*k -: 8]) begin
          r = close_image(1'b0, FMT_JPEG, CAUSE_SIG);
          hit = 1'b1;
        end else if (k == 10) begin
          // APP0 length counts its own two bytes plus the five tag bytes
          if (skip_left < 16'd7) begin
            r = close_image(1'b0, FMT_JPEG, CAUSE_SEG);
            hit = 1'b1;
          end else begin
            skip_left = skip_left - 16'd7;
            ph = PH_SKIP;
          end
        end
      end
      PH_PNG: begin
        hoff = hoff + 5'd1;
        if (k < 4) begin
          if (b != PNG_SIG[31 - 8*k -: 8]) begin
            r = close_image(1'b0, FMT_JPEG, CAUSE_SIG);
            hit = 1'b1;
          end
        end else begin
          if (k >= 16 && k <= 19) wcap = {wcap[23:0], b};
          if (k >= 20 && k <= 23) hcap = {hcap[23:0], b};
          if (k >= 23) begin
            r = close_image(1'b1, FMT_PNG, CAUSE_NONE);
            hit = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        if (skip_left != 16'd0) begin
          skip_left = skip_left - 16'd1;
        end else if (b != BYTE_FF) begin
          r = close_image(1'b0, FMT_JPEG, CAUSE_SEG);
          hit = 1'b1;
        end else begin
          ph = PH_MARK;
        end
      end
      PH_MARK: begin
        if (b == MARK_SOF) begin
          hoff = '0;
          wcap = '0;
          hcap = '0;
          ph   = PH_SOF;
        end else begin
          ph = PH_LENHI;
        end
      end
      PH_LENHI: begin
        len_hi = b;
        ph = PH_LENLO;
      end
      PH_LENLO: begin
        seg_len = {len_hi, b};
        if (seg_len < 16'd2) begin
          r = close_image(1'b0, FMT_JPEG, CAUSE_SEG);
          hit = 1'b1;
        end else begin
          skip_left = seg_len - 16'd2;
          ph = PH_SKIP;
        end
      end
      PH_SOF: begin
        // SOF0 body: length(2) precision(1) height(2) width(2)
        hoff = hoff + 5'd1;
        if (k == 3 || k == 4) hcap = {16'h0, hcap[7:0], b};
        if (k == 5 || k == 6) wcap = {16'h0, wcap[7:0], b};
        if (k >= 6) begin
          r = close_image(1'b1, FMT_JPEG, CAUSE_NONE);
          hit = 1'b1;
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  function automatic bit predict_item(input ihse_in_t it, output ihse_out_t r);
    bit hit;
    hit = 1'b0;
    r   = '0;
    if (!decided) hit = parse_byte(it.data_byte, r);
    if (it.final_byte) begin
      if (!hit && !decided) begin
        r = close_image(1'b0, FMT_JPEG, CAUSE_TRUNC);
        hit = 1'b1;
      end
      rearm();
    end
    return hit;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    ihse_out_t want;
    ihse_out_t got;
    bit        bad;
    if (!rst_ni) begin
      rearm();
      dims_due.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (predict_item(in_data_i, want)) dims_due.push_back(want);
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (dims_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result found=%0d fmt=%0d w=%0d h=%0d cause=%0d",
                     $time, got.found, got.image_format, got.frame_width,
                     got.frame_height, got.fail_cause);
        end else begin
          want = dims_due.pop_front();
          bad = (got.found        !== want.found)        ||
                (got.image_format !== want.image_format) ||
                (got.frame_width  !== want.frame_width)  ||
                (got.frame_height !== want.frame_height) ||
                (got.fail_cause   !== want.fail_cause);
          if (bad) begin
            fails++;
            if (fails <= 10)
              $display("%0t: mismatch expected found=%0d fmt=%0d w=%0d h=%0d cause=%0d, %s",
                       $time, want.found, want.image_format, want.frame_width,
                       want.frame_height, want.fail_cause, "see actual below");
            if (fails <= 10)
              $display("%0t:          actual found=%0d fmt=%0d w=%0d h=%0d cause=%0d",
                       $time, got.found, got.image_format, got.frame_width,
                       got.frame_height, got.fail_cause);
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= dims_due.size();
    end
  end

endmodule

// ===== tb/image_header_size_extractor_top_tb.sv =====
// Testbench top for the image header size extractor: builds JPEG/PNG byte
// streams (valid, broken and noise), drives both handshakes and gives the verdict.
// Depends on ihse_pkg, image_header_size_extractor_top and ihse_checker.
`timescale 1ns / 1ps

module image_header_size_extractor_top_tb;
  import ihse_pkg::*;

  localparam int ITEM_TARGET = 1600;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  ihse_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  ihse_out_t out_data;

  int fail_count;
  int pending;
  int tx_idle_pct = 6;
  int rx_idle_pct = 69;
  int bytes_sent  = 0;
  int cycles      = 0;
  bit hold_tgl    = 1'b0;
  bit hold_seen   = 1'b0;
  int hold_left   = 0;

  logic [7:0] img[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  image_header_size_extractor_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  ihse_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off whenever hold_tgl flips
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_tgl) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < rx_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, final_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_image();
    for (int i = 0; i < img.size(); i++) send_byte(img[i], i == img.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_dim();
    logic [31:0] d;
    case ($urandom_range(3, 0))
      0:       d = 32'h0;
      1:       d = 32'hFFFF_FFFF;
      2:       d = 32'h1 << $urandom_range(31, 0);
      default: d = $urandom;
    endcase
    return d;
  endfunction

  task automatic build_png();
    logic [31:0] w;
    logic [31:0] h;
    w = pick_dim();
    h = pick_dim();
    img = {8'h89, 8'h50, 8'h4E, 8'h47};
    repeat (12) img.push_back(8'($urandom_range(255, 0)));
    for (int i = 3; i >= 0; i--) img.push_back(w[8*i +: 8]);
    for (int i = 3; i >= 0; i--) img.push_back(h[8*i +: 8]);
  endtask

  task automatic build_jpeg(input bit short_app0, input bit short_seg);
    int          app_len;
    int          nseg;
    int          seg_len;
    logic [7:0]  mark;
    logic [31:0] w;
    logic [31:0] h;
    w = pick_dim();
    h = pick_dim();
    app_len = short_app0 ? $urandom_range(6, 0) : $urandom_range(16, 7);
    img = {8'hFF, 8'hD8, 8'hFF, 8'hE0, app_len[15:8], app_len[7:0],
           8'h4A, 8'h46, 8'h49, 8'h46, 8'h00};
    if (app_len > 7) repeat (app_len - 7) img.push_back(8'($urandom_range(255, 0)));
    nseg = short_seg ? $urandom_range(3, 1) : $urandom_range(3, 0);
    for (int i = 0; i < nseg; i++) begin
      do mark = 8'($urandom_range(255, 0)); while (mark == MARK_SOF);
      if (short_seg && i == nseg - 1) seg_len = $urandom_range(1, 0);
      else if ($urandom_range(19, 0) == 0) seg_len = $urandom_range(600, 2);
      else seg_len = $urandom_range(10, 2);
      img.push_back(BYTE_FF);
      img.push_back(mark);
      img.push_back(seg_len[15:8]);
      img.push_back(seg_len[7:0]);
      for (int j = 2; j < seg_len; j++) img.push_back(8'($urandom_range(255, 0)));
    end
    img.push_back(BYTE_FF);
    img.push_back(MARK_SOF);
    repeat (3) img.push_back(8'($urandom_range(255, 0)));
    img.push_back(h[15:8]);
    img.push_back(h[7:0]);
    img.push_back(w[15:8]);
    img.push_back(w[7:0]);
  endtask

  task automatic gen_image();
    int pick;
    int cut;
    int pos;
    pick = $urandom_range(99, 0);
    if (pick < 30) begin
      build_png();
    end else if (pick < 60) begin
      build_jpeg(1'b0, 1'b0);
    end else if (pick < 68) begin
      build_jpeg(1'b1, 1'b0);
    end else if (pick < 75) begin
      build_jpeg(1'b0, 1'b1);
    end else if (pick < 88) begin
      // cut short, final byte lands anywhere in the header
      if (pick[0]) build_png(); else build_jpeg(1'b0, 1'b0);
      cut = $urandom_range(img.size(), 1);
      while (img.size() > cut) img.delete(img.size() - 1);
    end else if (pick < 95) begin
      if (pick[0]) build_png(); else build_jpeg(1'b0, 1'b0);
      pos = $urandom_range(img.size() - 1, 0);
      img[pos] = 8'($urandom_range(255, 0));
    end else begin
      img.delete();
      repeat ($urandom_range(6, 1)) img.push_back(8'($urandom_range(255, 0)));
    end
    // trailing bytes after the deciding byte are ignored until final
    if (pick < 75) repeat ($urandom_range(3, 0)) img.push_back(8'($urandom_range(255, 0)));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: lone bytes, bad signatures, early final, bytes after a result
    img = {8'hFF};                      send_image();
    img = {8'h89};                      send_image();
    img = {8'h00};                      send_image();
    img = {8'hFF, 8'hFF};               send_image();
    img = {8'hFF, 8'hD8, 8'hFF, 8'hE1}; send_image();
    img = {8'h89, 8'h50, 8'h4E, 8'h46}; send_image();
    img = {8'hAB, 8'h12, 8'h34};        send_image();
    img = {8'h89, 8'h50, 8'h4E, 8'h47, 8'h00}; send_image();

    for (int stage = 0; stage < 3; stage++) begin
      tx_idle_pct = (stage == 0) ? 6 : (stage == 1) ? 69 : 0;
      rx_idle_pct = (stage == 0) ? 69 : (stage == 1) ? 6 : 0;
      if (stage == 2) begin
        // results back up during the hold-off until the input stalls
        hold_tgl <= ~hold_tgl;
        repeat (12) begin
          img.delete();
          img.push_back(8'($urandom_range(127, 0)));
          send_image();
        end
        wait_drained();
      end
      while (bytes_sent < ITEM_TARGET * (stage + 1) / 3) begin
        gen_image();
        send_image();
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ihse_pkg.sv
rtl/image_header_size_extractor_top.sv
tb/ihse_checker.sv
tb/image_header_size_extractor_top_tb.sv
